FILE: hw/rtl/tscm_pkg.sv
package tscm_pkg;

  localparam int PACKET_LENGTH_DEF = 188;

  localparam int PID_W       = 13;
  localparam int TABLE_DEPTH = 1 << PID_W;
  localparam int ENTRY_W     = 5;
  localparam int OFFSET_W    = 9;

  localparam logic [7:0]         SYNC_VALUE = 8'h47;
  localparam logic [PID_W-1:0]   NULL_PID   = 13'h1FFF;
  localparam logic [PID_W-1:0]   PAT_PID    = 13'h0000;
  localparam logic [PID_W-1:0]   SDT_PID    = 13'h0011;

  localparam logic [OFFSET_W-1:0] BASE_OFFSET  = 9'd4;
  localparam logic [OFFSET_W-1:0] ADAPT_OFFSET = 9'd5;

endpackage

FILE: hw/rtl/tscm_ram.sv
module tscm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ts_continuity_monitor_top.sv
// Transport stream continuity monitor. Each input transaction carries the
// first five header bytes of one packet; each output transaction carries
// the decoded header, the payload offset, the PSI forward flag and the
// continuity check result. A table of 8192 entries (one per PID, a seen
// mark plus the last continuity counter) lives in a single synchronous RAM.
// After reset the block sweeps that RAM to unseen, one entry per cycle;
// in_stall stays high until the sweep ends. After that, for each packet
// the accept cycle issues the RAM read and the next cycle compares,
// writes the entry back and loads the output register; the check waits
// on the synchronous RAM read. The next packet
// is taken once the lookup is done, but only while the output register is
// empty or hands its result over in that same cycle; a result held by
// out_stall keeps in_stall high until it leaves. Packets with a bad sync
// byte report sync_ok = 0 with all other fields zero and leave the table
// alone; null PID packets and packets without payload are not checked or
// recorded.
module ts_continuity_monitor_top #(
  parameter int PACKET_LENGTH = tscm_pkg::PACKET_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    sync_byte,
  input  logic [7:0]                    flags_pid_high,
  input  logic [7:0]                    pid_low,
  input  logic [7:0]                    control_byte,
  input  logic [7:0]                    adaptation_length,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          sync_ok,
  output logic                          transport_error,
  output logic                          scrambled,
  output logic [tscm_pkg::PID_W-1:0]    packet_id,
  output logic                          has_payload,
  output logic                          counter_error,
  output logic                          payload_start,
  output logic [tscm_pkg::OFFSET_W-1:0] payload_offset,
  output logic                          forward_psi
);

  // FSM codes
  localparam logic [1:0] ST_CLEAR = 2'd0;  // post-reset table sweep
  localparam logic [1:0] ST_IDLE  = 2'd1;  // ready for a header
  localparam logic [1:0] ST_LOOK  = 2'd2;  // RAM data valid, check + write back

  logic [1:0] state;
  logic [1:0] state_next;

  logic [tscm_pkg::PID_W-1:0] clr_cnt;

  // header bytes captured at accept
  logic [7:0] b0_q;
  logic [7:0] b1_q;
  logic [7:0] b2_q;
  logic [7:0] b3_q;
  logic [7:0] b4_q;

  logic in_accept;
  logic out_accept;

  // table RAM
  logic                          tbl_we;
  logic [tscm_pkg::PID_W-1:0]    tbl_waddr;
  logic [tscm_pkg::ENTRY_W-1:0]  tbl_wdata;
  logic [tscm_pkg::PID_W-1:0]    tbl_raddr;
  logic [tscm_pkg::ENTRY_W-1:0]  tbl_rdata;

  // decode of the captured header
  logic                          hdr_sync;
  logic [tscm_pkg::PID_W-1:0]    hdr_pid;
  logic [1:0]                    hdr_actl;
  logic [3:0]                    hdr_cc;
  logic                          hdr_payload;
  logic                          hdr_check;
  logic [3:0]                    cc_expect;
  logic                          hdr_cerr;
  logic [tscm_pkg::OFFSET_W-1:0] hdr_offset;
  logic                          hdr_psi;

  assign in_stall   = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Read address comes straight from the port, so the entry is ready in
  // the cycle after accept.
  assign tbl_raddr = {flags_pid_high[4:0], pid_low};

  assign hdr_sync    = (b0_q == tscm_pkg::SYNC_VALUE);
  assign hdr_pid     = {b1_q[4:0], b2_q};
  assign hdr_actl    = b3_q[5:4];
  assign hdr_cc      = b3_q[3:0];
  assign hdr_payload = hdr_actl[0];   // adaptation control 1 or 3
  assign hdr_check   = hdr_sync && hdr_payload && (hdr_pid != tscm_pkg::NULL_PID);
  assign cc_expect   = tbl_rdata[3:0] + 4'd1;
  assign hdr_cerr    = hdr_check && tbl_rdata[4] && (hdr_cc != cc_expect);
  assign hdr_offset  = hdr_actl[1] ? (tscm_pkg::ADAPT_OFFSET + {1'b0, b4_q})
                                   : tscm_pkg::BASE_OFFSET;
  assign hdr_psi     = hdr_payload
                    && ((hdr_pid == tscm_pkg::PAT_PID) || (hdr_pid == tscm_pkg::SDT_PID))
                    && (hdr_offset < tscm_pkg::OFFSET_W'(PACKET_LENGTH));

  // Write port: sweep during clear, record the counter during lookup.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = hdr_pid;
    tbl_wdata = {1'b1, hdr_cc};
    case (state)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt;
        tbl_wdata = '0;
      end
      ST_LOOK: begin
        tbl_we = hdr_check;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b0_q <= sync_byte;
      b1_q <= flags_pid_high;
      b2_q <= pid_low;
      b3_q <= control_byte;
      b4_q <= adaptation_length;
    end
  end

  // Output register. The accept rule guarantees it is empty (or drained)
  // by the time a lookup completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LOOK) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      sync_ok         <= hdr_sync;
      transport_error <= hdr_sync && b1_q[7];
      scrambled       <= hdr_sync && (b3_q[7:6] != 2'b00);
      packet_id       <= hdr_sync ? hdr_pid : '0;
      has_payload     <= hdr_sync && hdr_payload;
      counter_error   <= hdr_cerr;
      payload_start   <= hdr_sync && b1_q[6];
      payload_offset  <= hdr_sync ? hdr_offset : '0;
      forward_psi     <= hdr_sync && hdr_psi;
    end
  end

  tscm_ram #(
    .WIDTH (tscm_pkg::ENTRY_W),
    .DEPTH (tscm_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

endmodule

FILE: hw/rtl/tscm_checker.sv
module tscm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    sync_byte,
  input logic [7:0]                    flags_pid_high,
  input logic [7:0]                    pid_low,
  input logic [7:0]                    control_byte,
  input logic [7:0]                    adaptation_length,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          sync_ok,
  input logic                          transport_error,
  input logic                          scrambled,
  input logic [tscm_pkg::PID_W-1:0]    packet_id,
  input logic                          has_payload,
  input logic                          counter_error,
  input logic                          payload_start,
  input logic [tscm_pkg::OFFSET_W-1:0] payload_offset,
  input logic                          forward_psi
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packet_id) && $stable(counter_error)
      && $stable(payload_offset))
    else $error("output transaction changed while stalled");

  // each accepted header produces a result once its lookup is done, with out_valid low during the lookup
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid ##1 out_valid)
    else $error("result not delivered after lookup");

  // bad sync reports nothing else
  a_bad_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sync_ok |-> !transport_error && !scrambled && (packet_id == '0)
      && !has_payload && !counter_error && !payload_start && (payload_offset == '0)
      && !forward_psi)
    else $error("fields set on bad sync");

  // continuity errors only on checked packets
  a_cerr_scope: assert property (@(posedge clk) disable iff (rst)
    out_valid && counter_error |-> sync_ok && has_payload
      && (packet_id != tscm_pkg::NULL_PID))
    else $error("counter error on unchecked packet");

  // PSI forwarding only for PAT/SDT with payload
  a_psi_scope: assert property (@(posedge clk) disable iff (rst)
    out_valid && forward_psi |-> has_payload
      && ((packet_id == tscm_pkg::PAT_PID) || (packet_id == tscm_pkg::SDT_PID)))
    else $error("PSI forward on wrong packet");

endmodule

bind ts_continuity_monitor_top tscm_checker u_tscm_checker (.*);
